[sv/phase_weighted_property_average_assert.svh]
// ----------------------------------------------------------------------------
// phase weighted property average assertion macros
// shared property checks sampled on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PHASE_WEIGHTED_PROPERTY_AVERAGE_ASSERT_SVH
`define PHASE_WEIGHTED_PROPERTY_AVERAGE_ASSERT_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define PWPA_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define PWPA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pwpa_pkg.sv]
// ----------------------------------------------------------------------------
// pwpa_pkg
// types, constants and helpers shared by the phase weighted average block
// ----------------------------------------------------------------------------
`default_nettype none

package pwpa_pkg;

	localparam int LANES      = 4;
	localparam int PHASE_W    = 16;
	localparam int PROP_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int HARM_SHIFT = FRAC_BITS + 16;
	localparam int W_W        = 15;
	localparam int WSUM_W     = 17;
	localparam int PROD_W     = 48;
	localparam int TERM_W     = W_W + HARM_SHIFT;
	localparam int FIN_W      = 49;
	localparam int LANE_LAT   = 1 + TERM_W;
	localparam int ONE_Q14    = 16384;

	localparam logic [1:0] MODE_ARITH = 2'd0;
	localparam logic [1:0] MODE_HARM  = 2'd1;
	localparam logic [1:0] MODE_MAX   = 2'd2;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_MAX,
		KIND_NONE,
		KIND_ZW,
		KIND_ARITH,
		KIND_HARM
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [LANES-1:0]  mask;
		logic [WSUM_W-1:0] wsum;
		logic [PROP_W-1:0] value;
	} ctx_t;

	typedef struct packed {
		logic [TERM_W-1:0]        term;
		logic signed [PROD_W-1:0] prod;
		logic                     neg;
		logic                     nz;
	} lane_res_t;

	typedef struct packed {
		kind_t             kind;
		logic [PROP_W-1:0] value;
		logic              neg;
		logic              tz;
	} fin_side_t;

	function automatic logic [W_W-1:0] clamp_weight(input logic signed [PHASE_W-1:0] ph);
		logic [W_W-1:0] w;
		if (ph[PHASE_W-1]) begin
			w = '0;
		end else if (ph > PHASE_W'(ONE_Q14)) begin
			w = W_W'(ONE_Q14);
		end else begin
			w = ph[W_W-1:0];
		end
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/phase_weighted_property_average.sv]
// Phase weighted property average. Every word carries four Q1.14 phase
// fractions and four Q16.16 properties and gives one averaged property.
// Four lanes clamp the fractions, form the weighted products and divide out
// the harmonic terms side by side; the merge stages sum the lanes and a single
// 49-stage divider forms the final mean. One word is taken every cycle while
// the output is not stalled; on its way to the result each word passes the
// lane input register (1 stage), the lane divider (47 stages), the merge (4
// stages), the final divider (49 stages) and the output register (1 stage).
// The pipeline halts as a whole while a finished result waits at the output.
// ----------------------------------------------------------------------------
// phase_weighted_property_average
// arithmetic, harmonic or largest-phase average of up to four phase properties
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_weighted_property_average_assert.svh"

module phase_weighted_property_average
	import pwpa_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [2:0]                cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [PHASE_W-1:0] phase_0,
	input  wire logic signed [PHASE_W-1:0] phase_1,
	input  wire logic signed [PHASE_W-1:0] phase_2,
	input  wire logic signed [PHASE_W-1:0] phase_3,
	input  wire logic signed [PROP_W-1:0]  property_0,
	input  wire logic signed [PROP_W-1:0]  property_1,
	input  wire logic signed [PROP_W-1:0]  property_2,
	input  wire logic signed [PROP_W-1:0]  property_3,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [PROP_W-1:0]       average,
	output logic                           zero_weight,
	output logic                           saturated
);

	logic [1:0] mode_q;
	logic [2:0] count_q;
	logic       en;

	logic signed [PHASE_W-1:0] ph [LANES];
	logic signed [PROP_W-1:0]  pr [LANES];
	logic                      lane_vld [LANES];
	lane_res_t                 lane_res [LANES];

	ctx_t ctx_in;
	ctx_t ctx_q [LANE_LAT];

	// merge stages
	logic signed [PROD_W:0]   apair_s1 [2];
	logic signed [TERM_W+1:0] hpair_s1 [2];
	ctx_t                     ctx_s1;
	logic                     vld_s1;
	logic signed [FIN_W-1:0]  asum_s2;
	logic signed [FIN_W:0]    tsum_s2;
	ctx_t                     ctx_s2;
	logic                     vld_s2;
	logic [FIN_W-1:0]         num_s3;
	logic [FIN_W-1:0]         den_s3;
	fin_side_t                side_s3;
	logic                     vld_s3;
	logic [FIN_W-1:0]         num_s4;
	logic [FIN_W-1:0]         den_s4;
	fin_side_t                side_s4;
	logic                     vld_s4;

	logic                     fin_vld;
	logic [FIN_W-1:0]         fin_quot;
	logic [$bits(fin_side_t)-1:0] fin_side_raw;
	fin_side_t                fin_side;

	logic signed [PROP_W-1:0] avg_d;
	logic                     zw_d;
	logic                     sat_d;
	logic signed [PROP_W-1:0] avg_q;
	logic                     zw_q;
	logic                     sat_q;
	logic                     out_vld_q;

	assign en       = ~out_vld_q | out_ready;
	assign in_ready = en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ARITH;
			count_q <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_COUNT: count_q <= cfg_data;
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	assign ph[0] = phase_0;
	assign ph[1] = phase_1;
	assign ph[2] = phase_2;
	assign ph[3] = phase_3;
	assign pr[0] = property_0;
	assign pr[1] = property_1;
	assign pr[2] = property_2;
	assign pr[3] = property_3;

	// word context
	always_comb begin
		logic [2:0]                n_eff;
		logic signed [PHASE_W-1:0] best;
		logic [PROP_W-1:0]         val;
		logic [WSUM_W-1:0]         ws;
		n_eff = count_q;
		if (count_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (count_q > 3'(LANES)) begin
			n_eff = 3'(LANES);
		end
		ws   = '0;
		best = ph[0];
		val  = pr[0];
		for (int i = 0; i < LANES; i++) begin
			ctx_in.mask[i] = (3'(i) < n_eff);
			if (3'(i) < n_eff) begin
				ws = ws + WSUM_W'(clamp_weight(ph[i]));
			end
			if (i > 0 && 3'(i) < n_eff && ph[i] > best) begin
				best = ph[i];
				val  = pr[i];
			end
		end
		ctx_in.wsum  = ws;
		ctx_in.value = (n_eff == 3'd1) ? pr[0] : val;
		if (n_eff == 3'd1) begin
			ctx_in.kind = KIND_PASS;
		end else begin
			case (mode_q)
				MODE_ARITH: ctx_in.kind = (ws == '0) ? KIND_ZW : KIND_ARITH;
				MODE_HARM:  ctx_in.kind = (ws == '0) ? KIND_ZW : KIND_HARM;
				MODE_MAX:   ctx_in.kind = KIND_MAX;
				default:    ctx_in.kind = KIND_NONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q[0] <= ctx_in;
			for (int k = 1; k < LANE_LAT; k++) begin
				ctx_q[k] <= ctx_q[k-1];
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		pwpa_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (in_valid),
			.phase    (ph[i]),
			.prop     (pr[i]),
			.out_valid(lane_vld[i]),
			.res      (lane_res[i])
		);
	end

	// merge: pair sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= lane_vld[0];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 2; p++) begin
				logic signed [PROD_W-1:0]   a0, a1;
				logic signed [TERM_W:0]     t0, t1;
				a0 = ctx_q[LANE_LAT-1].mask[2*p]   ? lane_res[2*p].prod   : '0;
				a1 = ctx_q[LANE_LAT-1].mask[2*p+1] ? lane_res[2*p+1].prod : '0;
				t0 = '0;
				t1 = '0;
				if (ctx_q[LANE_LAT-1].mask[2*p] && lane_res[2*p].nz) begin
					t0 = lane_res[2*p].neg ? -$signed({1'b0, lane_res[2*p].term})
						: $signed({1'b0, lane_res[2*p].term});
				end
				if (ctx_q[LANE_LAT-1].mask[2*p+1] && lane_res[2*p+1].nz) begin
					t1 = lane_res[2*p+1].neg ? -$signed({1'b0, lane_res[2*p+1].term})
						: $signed({1'b0, lane_res[2*p+1].term});
				end
				apair_s1[p] <= (PROD_W+1)'(a0) + (PROD_W+1)'(a1);
				hpair_s1[p] <= (TERM_W+2)'(t0) + (TERM_W+2)'(t1);
			end
			ctx_s1 <= ctx_q[LANE_LAT-1];
		end
	end

	// merge: totals
	always_ff @(posedge clk) begin
		if (en) begin
			asum_s2 <= FIN_W'(apair_s1[0]) + FIN_W'(apair_s1[1]);
			tsum_s2 <= (FIN_W+1)'(hpair_s1[0]) + (FIN_W+1)'(hpair_s1[1]);
			ctx_s2  <= ctx_s1;
		end
	end

	// merge: magnitudes and divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.kind  <= ctx_s2.kind;
			side_s3.value <= ctx_s2.value;
			side_s3.tz    <= (tsum_s2 == '0);
			if (ctx_s2.kind == KIND_HARM) begin
				num_s3       <= FIN_W'({ctx_s2.wsum, HARM_SHIFT'(0)});
				den_s3       <= tsum_s2[FIN_W] ? FIN_W'(-tsum_s2) : tsum_s2[FIN_W-1:0];
				side_s3.neg  <= tsum_s2[FIN_W];
			end else begin
				num_s3       <= asum_s2[FIN_W-1] ? FIN_W'(-asum_s2) : asum_s2;
				den_s3       <= FIN_W'(ctx_s2.wsum);
				side_s3.neg  <= asum_s2[FIN_W-1];
			end
		end
	end

	// rounding offset
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= num_s3 + (den_s3 >> 1);
			den_s4  <= den_s3;
			side_s4 <= side_s3;
		end
	end

	pwpa_div #(
		.NW(FIN_W),
		.DW(FIN_W),
		.SW($bits(fin_side_t))
	) u_fin_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side     (side_s4),
		.out_valid(fin_vld),
		.quot     (fin_quot),
		.out_side (fin_side_raw)
	);

	assign fin_side = fin_side_t'(fin_side_raw);

	// saturation and flags
	always_comb begin
		avg_d = '0;
		zw_d  = 1'b0;
		sat_d = 1'b0;
		case (fin_side.kind)
			KIND_PASS, KIND_MAX: avg_d = fin_side.value;
			KIND_ZW:             zw_d  = 1'b1;
			KIND_ARITH, KIND_HARM: begin
				if (!(fin_side.kind == KIND_HARM && fin_side.tz)) begin
					if (fin_side.neg) begin
						if (fin_quot > FIN_W'(64'h8000_0000)) begin
							avg_d = 32'h8000_0000;
							sat_d = 1'b1;
						end else begin
							avg_d = -$signed(fin_quot[PROP_W-1:0]);
						end
					end else begin
						if (fin_quot > FIN_W'(64'h7fff_ffff)) begin
							avg_d = 32'h7fff_ffff;
							sat_d = 1'b1;
						end else begin
							avg_d = fin_quot[PROP_W-1:0];
						end
					end
				end
			end
			default: avg_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= fin_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			avg_q <= avg_d;
			zw_q  <= zw_d;
			sat_q <= sat_d;
		end
	end

	assign out_valid   = out_vld_q;
	assign average     = avg_q;
	assign zero_weight = zw_q;
	assign saturated   = sat_q;

	`PWPA_ASSERT_SAME(a_flags_excl, out_valid, !(zero_weight && saturated), "both flags set")
	`PWPA_ASSERT_SAME(a_zw_zero, out_valid && zero_weight, average == '0, "zero weight not 0")
	`PWPA_ASSERT_SAME(a_sat_bound, out_valid && saturated,
		average == 32'sh7fff_ffff || average == 32'sh8000_0000, "saturated off bound")
	`PWPA_ASSERT_NEXT(a_hold_stall, fin_vld && !en, fin_vld && $stable(fin_quot),
		"final divider moved while stalled")

endmodule

`default_nettype wire

[sv/pwpa_div.sv]
// ----------------------------------------------------------------------------
// pwpa_div
// restoring unsigned divider, one quotient bit per stage, one word per cycle while en is high
// ----------------------------------------------------------------------------
`default_nettype none

module pwpa_div #(
	parameter int NW = 47,
	parameter int DW = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_valid,
	output logic [NW-1:0]      quot,
	output logic [SW-1:0]      out_side
);

	logic [NW-1:0] num_q  [NW];
	logic [DW-1:0] rem_q  [NW];
	logic [DW-1:0] den_q  [NW];
	logic [SW-1:0] side_q [NW];
	logic          vld_q  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] n_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] s_in;
		logic          v_in;
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
			assign s_in = side;
			assign v_in = in_valid;
		end else begin : g_next
			assign n_in = num_q[k-1];
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign s_in = side_q[k-1];
			assign v_in = vld_q[k-1];
		end

		assign trial = {r_in, n_in[NW-1]};
		assign diff  = {1'b0, trial} - {2'b00, d_in};
		assign ge    = ~diff[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k]  <= {n_in[NW-2:0], ge};
				rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_q[k]  <= d_in;
				side_q[k] <= s_in;
			end
		end
	end

	assign out_valid = vld_q[NW-1];
	assign quot      = num_q[NW-1];
	assign out_side  = side_q[NW-1];

endmodule

`default_nettype wire

[sv/pwpa_lane.sv]
// ----------------------------------------------------------------------------
// pwpa_lane
// one phase: clamped weight, weighted product and harmonic term
// ----------------------------------------------------------------------------
`default_nettype none

module pwpa_lane
	import pwpa_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic signed [PHASE_W-1:0] phase,
	input  wire logic signed [PROP_W-1:0]  prop,
	output logic                           out_valid,
	output lane_res_t                      res
);

	localparam int SIDE_W = PROD_W + 2;

	logic [W_W-1:0]           w;
	logic signed [PROD_W:0]   prod_full;
	logic [W_W-1:0]           w_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [PROP_W-1:0]        mag_s1;
	logic                     neg_s1;
	logic                     nz_s1;
	logic                     vld_s1;
	logic [SIDE_W-1:0]        side_out;

	assign w         = clamp_weight(phase);
	assign prod_full = $signed({2'b00, w}) * prop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= w;
			prod_s1 <= prod_full[PROD_W-1:0];
			mag_s1  <= prop[PROP_W-1] ? PROP_W'(-prop) : prop;
			neg_s1  <= prop[PROP_W-1];
			nz_s1   <= (prop != '0);
		end
	end

	pwpa_div #(
		.NW(TERM_W),
		.DW(PROP_W),
		.SW(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.num      ({w_s1, HARM_SHIFT'(0)}),
		.den      (mag_s1),
		.side     ({prod_s1, neg_s1, nz_s1}),
		.out_valid(out_valid),
		.quot     (res.term),
		.out_side (side_out)
	);

	assign res.prod = side_out[SIDE_W-1:2];
	assign res.neg  = side_out[1];
	assign res.nz   = side_out[0];

endmodule

`default_nettype wire
